>>> src/gst_pkg.sv
// Shared types and constants for the gray Sobel threshold stream.
// Used by the line store and the top level; depends on nothing else.
package gst_pkg;

    // One gray pixel.
    typedef logic [7:0] t_pix;

    // One line store word: the pixel two rows up (older) and one row up (newer).
    typedef struct packed {
        t_pix older;
        t_pix newer;
    } t_pix_pair;

    // Configuration register indexes.
    localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

    // Configuration reset values.
    localparam logic [10:0] IMAGE_WIDTH_RESET    = 11'd640;
    localparam logic [12:0] IMAGE_HEIGHT_RESET   = 13'd480;
    localparam logic [7:0]  EDGE_THRESHOLD_RESET = 8'd150;

    // Luma weights, scaled by 256.
    localparam logic [15:0] GRAY_COEF_RED   = 16'h004C;
    localparam logic [15:0] GRAY_COEF_GREEN = 16'h0096;
    localparam logic [15:0] GRAY_COEF_BLUE  = 16'h001D;

    // Full white level.
    localparam logic [10:0] LEVEL_WHITE = 11'd255;

endpackage

>>> src/gst_line_store.sv
// Line store memory holding the two previous gray rows, one word per column.
// One write port and one registered read port; uses gst_pkg.
module gst_line_store #(
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output gst_pkg::t_pix_pair       o_rd_data,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  gst_pkg::t_pix_pair       i_wr_data
);

    gst_pkg::t_pix_pair r_mem [DEPTH];
    gst_pkg::t_pix_pair r_rd_data;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> src/gray_sobel_threshold_stream.sv
// Top level of the streaming RGB to gray, 3x3 Sobel and threshold block.
// Depends on gst_pkg and gst_line_store.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+-----------------------------------
//  pixel   | in        | i_valid / o_ready           | i_red, i_green, i_blue
//  result  | out       | o_valid / i_ready           | o_edge_level, o_edge_bit, o_frame_last
//  config  | in        | i_cfg_valid / o_cfg_ready   | i_cfg_index, i_cfg_data
//
// One pixel is taken per cycle while no stall holds the pipeline; a result leaves once its pixel
// has passed the input stage with line store read, the window stage and the output register.
// The line store has one read and one write port, which sets the one pixel per cycle rate.
// Reset clears the counters, window and valid flags; the line store is not cleared, a fill
// count makes unwritten columns read as zero, so no clearing pass is needed.
// A stalled result stalls the stages behind it; border pixels drop out at the window stage.
module gray_sobel_threshold_stream #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_red,
    input  logic [7:0]  i_green,
    input  logic [7:0]  i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_edge_level,
    output logic        o_edge_bit,
    output logic        o_frame_last,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    typedef logic [2:0][2:0][7:0] t_win;

    // Configuration registers.
    logic [10:0] r_image_width;
    logic [12:0] r_image_height;
    logic [7:0]  r_edge_threshold;

    // Raster position of the next pixel and line store fill count.
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [CW:0]   r_fill;

    // Input stage.
    logic          r_a_valid;
    logic [7:0]    r_a_red, r_a_green, r_a_blue;
    logic [CW-1:0] r_a_col;
    logic          r_a_fill_ok;
    logic          r_a_emit;
    logic          r_a_last;

    // Window stage.
    logic r_b_valid;
    logic r_b_emit;
    logic r_b_last;
    t_win r_win, n_win;

    // Output register.
    logic       r_o_valid;
    logic [7:0] r_o_level;
    logic       r_o_bit;
    logic       r_o_last;

    logic [CW-1:0] w_m1;
    logic [RW-1:0] h_m1;
    logic          row_end, frame_end, emit;
    logic          in_acc, a_adv, b_free, b_adv, out_free;
    logic          cfg_acc;

    gst_pkg::t_pix_pair rd_pair, wr_pair;
    gst_pkg::t_pix      top, mid, gray;
    logic [15:0]        gray_sum;

    logic [9:0]  xp, xn, yp, yn, ax, ay;
    logic [10:0] mag;
    logic [7:0]  level;

    // Clamp the frame size registers to the supported range.
    always_comb begin
        if (r_image_width < 11'd3) begin
            w_m1 = CW'(2);
        end else if (32'(r_image_width) > MAX_WIDTH) begin
            w_m1 = CW'(MAX_WIDTH - 1);
        end else begin
            w_m1 = CW'(r_image_width - 11'd1);
        end
        if (r_image_height < 13'd3) begin
            h_m1 = RW'(2);
        end else if (32'(r_image_height) > MAX_HEIGHT) begin
            h_m1 = RW'(MAX_HEIGHT - 1);
        end else begin
            h_m1 = RW'(r_image_height - 13'd1);
        end
    end

    // Pipeline flow control.
    assign out_free = !r_o_valid || i_ready;
    assign b_adv    = r_b_valid && (!r_b_emit || out_free);
    assign b_free   = !r_b_valid || b_adv;
    assign a_adv    = r_a_valid && b_free;
    assign o_ready  = !r_a_valid || a_adv;
    assign in_acc   = i_valid && o_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid;

    // Position decode of the incoming pixel.
    assign row_end   = r_col >= w_m1;
    assign frame_end = row_end && (r_row >= h_m1);
    assign emit      = (r_col >= CW'(2)) && (r_row >= RW'(2));

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (row_end) begin
            n_col = '0;
            n_row = frame_end ? '0 : r_row + RW'(1);
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width    <= gst_pkg::IMAGE_WIDTH_RESET;
            r_image_height   <= gst_pkg::IMAGE_HEIGHT_RESET;
            r_edge_threshold <= gst_pkg::EDGE_THRESHOLD_RESET;
        end else if (cfg_acc) begin
            case (i_cfg_index)
                gst_pkg::CFG_IMAGE_WIDTH:    r_image_width    <= i_cfg_data[10:0];
                gst_pkg::CFG_IMAGE_HEIGHT:   r_image_height   <= i_cfg_data;
                gst_pkg::CFG_EDGE_THRESHOLD: r_edge_threshold <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Line store: read the column at accept, write back when the pixel leaves the input stage.
    assign top     = r_a_fill_ok ? rd_pair.older : '0;
    assign mid     = r_a_fill_ok ? rd_pair.newer : '0;
    assign wr_pair = '{older: mid, newer: gray};

    gst_line_store #(
        .DEPTH(MAX_WIDTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_acc),
        .i_rd_addr (r_col),
        .o_rd_data (rd_pair),
        .i_wr_en   (a_adv),
        .i_wr_addr (r_a_col),
        .i_wr_data (wr_pair)
    );

    // Gray conversion of the pixel in the input stage.
    assign gray_sum = 16'(r_a_red) * gst_pkg::GRAY_COEF_RED
                    + 16'(r_a_green) * gst_pkg::GRAY_COEF_GREEN
                    + 16'(r_a_blue) * gst_pkg::GRAY_COEF_BLUE;
    assign gray = gray_sum[15:8];

    // Shift the window left by one column and insert the new column.
    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[i][0] = r_win[i][1];
            n_win[i][1] = r_win[i][2];
        end
        n_win[0][2] = top;
        n_win[1][2] = mid;
        n_win[2][2] = gray;
    end

    // Control registers: counters, fill count, stage flags and window.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_fill    <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
            r_win     <= '0;
        end else begin
            if (in_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (a_adv && ({1'b0, r_a_col} == r_fill)) begin
                r_fill <= r_fill + (CW+1)'(1);
            end
            if (in_acc) begin
                r_a_valid <= 1'b1;
            end else if (a_adv) begin
                r_a_valid <= 1'b0;
            end
            if (a_adv) begin
                r_b_valid <= 1'b1;
                r_win     <= n_win;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            if (b_adv && r_b_emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_a_red     <= i_red;
            r_a_green   <= i_green;
            r_a_blue    <= i_blue;
            r_a_col     <= r_col;
            r_a_fill_ok <= {1'b0, r_col} < r_fill;
            r_a_emit    <= emit;
            r_a_last    <= frame_end;
        end
        if (a_adv) begin
            r_b_emit <= r_a_emit;
            r_b_last <= r_a_last;
        end
        if (b_adv && r_b_emit) begin
            r_o_level <= level;
            r_o_bit   <= level > r_edge_threshold;
            r_o_last  <= r_b_last;
        end
    end

    // Sobel magnitude of the window and inverted, clamped level.
    always_comb begin
        xp  = {2'b00, r_win[0][2]} + {1'b0, r_win[1][2], 1'b0} + {2'b00, r_win[2][2]};
        xn  = {2'b00, r_win[0][0]} + {1'b0, r_win[1][0], 1'b0} + {2'b00, r_win[2][0]};
        yp  = {2'b00, r_win[0][0]} + {1'b0, r_win[0][1], 1'b0} + {2'b00, r_win[0][2]};
        yn  = {2'b00, r_win[2][0]} + {1'b0, r_win[2][1], 1'b0} + {2'b00, r_win[2][2]};
        ax  = (xp >= xn) ? xp - xn : xn - xp;
        ay  = (yp >= yn) ? yp - yn : yn - yp;
        mag = {1'b0, ax} + {1'b0, ay};
        if (mag >= gst_pkg::LEVEL_WHITE) begin
            level = '0;
        end else begin
            level = 8'(gst_pkg::LEVEL_WHITE - mag);
        end
    end

    assign o_valid      = r_o_valid;
    assign o_edge_level = r_o_level;
    assign o_edge_bit   = r_o_bit;
    assign o_frame_last = r_o_last;

`ifndef SYNTH
    // The fill count never passes the line store depth.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= (CW+1)'(MAX_WIDTH))
        else $error("line store fill count beyond depth");

    // Columns are written in order, so a write never skips past the fill count.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_adv |-> ({1'b0, r_a_col} <= r_fill))
        else $error("line store write beyond fill count");

    // The last pixel of a frame wraps both counters.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && frame_end) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap at frame end");

    // A blocked input stage keeps its pixel.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !a_adv) |=> (r_a_valid && $stable(r_a_col)))
        else $error("input stage lost a stalled pixel");

    // A result only appears from an interior window.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_o_valid) |-> $past(r_b_valid && r_b_emit))
        else $error("result produced for a border pixel");
`endif

endmodule

>>> tb/gray_sobel_threshold_stream_test.sv
// Self-checking testbench for the gray Sobel threshold stream block.
// Depends on gst_pkg and gray_sobel_threshold_stream; the expected edge results come
// from a behavioral predictor kept in this file.
module gray_sobel_threshold_stream_test;

    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 4096;
    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int DRAIN_CYCLES   = 8;
    localparam int QUIET_LIMIT    = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int RANDOM_ITEMS   = 480;
    localparam int WIDE_ROW_ITEMS = 40;
    localparam int GRAY_W_RED     = 76;
    localparam int GRAY_W_GREEN   = 150;
    localparam int GRAY_W_BLUE    = 29;
    localparam int WHITE_LEVEL    = 255;

    // Index that maps to no register; a write there must change nothing.
    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    // Picture content styles for generated frames.
    typedef enum int {
        CONTENT_NOISE,
        CONTENT_SMOOTH,
        CONTENT_FLAT,
        CONTENT_BLOCKS,
        CONTENT_EXTREME
    } t_content;

    // One expected edge result.
    typedef struct {
        logic [7:0] level;
        logic       white;
        logic       frame_end;
    } t_edge_result;

    // Block ports.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_red = 8'd0;
    logic [7:0]  i_green = 8'd0;
    logic [7:0]  i_blue = 8'd0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_edge_level;
    logic        o_edge_bit;
    logic        o_frame_last;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = 2'd0;
    logic [12:0] i_cfg_data = 13'd0;

    // Predictor state: configuration, line stores, window and position counters.
    logic [10:0] cfg_width;
    logic [12:0] cfg_height;
    logic [7:0]  cfg_threshold;
    logic [7:0]  prev_row_gray [MAX_WIDTH];
    logic [7:0]  older_row_gray [MAX_WIDTH];
    logic [7:0]  gray_win [3][3];
    int          next_col;
    int          next_row;

    t_edge_result expected_edges[$];
    t_edge_result want_edge;
    int           fail_count = 0;
    int           pixels_sent = 0;
    int           quiet_cycles = 0;
    int           stall_left = 0;
    bit           full_rate = 1'b0;

    gray_sobel_threshold_stream #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_edge_level(o_edge_level),
        .o_edge_bit  (o_edge_bit),
        .o_frame_last(o_frame_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Frame dimensions in use are held to 3..max.
    function automatic int clamp_dim(input int v, input int hi);
        if (v < 3) return 3;
        if (v > hi) return hi;
        return v;
    endfunction

    // Pixels still to come before the current frame ends.
    function automatic int frame_remaining();
        int w;
        int h;
        int rest_row;
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        rest_row = (next_col >= w - 1) ? 1 : w - next_col;
        if (next_row >= h - 1) return rest_row;
        return rest_row + (h - 1 - next_row) * w;
    endfunction

    // Advances the predictor by one pixel and queues the edge result it causes, if any.
    task automatic predict_edge(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        int           w;
        int           h;
        int           i;
        int           gx;
        int           gy;
        int           lvl;
        logic [9:0]   idx;
        logic [7:0]   gray;
        logic [7:0]   top;
        logic [7:0]   mid;
        logic         row_end;
        logic         frame_end;
        t_edge_result res;
        gray = 8'((r * GRAY_W_RED + g * GRAY_W_GREEN + b * GRAY_W_BLUE) >> 8);
        w = clamp_dim(cfg_width, MAX_WIDTH);
        h = clamp_dim(cfg_height, MAX_HEIGHT);
        idx = 10'(next_col);
        top = older_row_gray[idx];
        mid = prev_row_gray[idx];
        row_end = (next_col >= w - 1);
        frame_end = row_end && (next_row >= h - 1);
        older_row_gray[idx] = mid;
        prev_row_gray[idx] = gray;

        // Shift the window left and bring in the new column.
        for (i = 0; i < 3; i++) begin
            gray_win[i][0] = gray_win[i][1];
            gray_win[i][1] = gray_win[i][2];
        end
        gray_win[0][2] = top;
        gray_win[1][2] = mid;
        gray_win[2][2] = gray;

        // Interior pixels only: the window holds three full rows and columns.
        if (next_col >= 2 && next_row >= 2) begin
            gx = -int'(gray_win[0][0]) + int'(gray_win[0][2])
                 - 2 * int'(gray_win[1][0]) + 2 * int'(gray_win[1][2])
                 - int'(gray_win[2][0]) + int'(gray_win[2][2]);
            gy = int'(gray_win[0][0]) + 2 * int'(gray_win[0][1]) + int'(gray_win[0][2])
                 - int'(gray_win[2][0]) - 2 * int'(gray_win[2][1]) - int'(gray_win[2][2]);
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            lvl = WHITE_LEVEL - gx - gy;
            if (lvl < 0) lvl = 0;
            res.level = 8'(lvl);
            res.white = (lvl > int'(cfg_threshold));
            res.frame_end = frame_end;
            expected_edges.push_back(res);
        end

        // Raster position of the next pixel.
        if (row_end) begin
            next_col = 0;
            next_row = frame_end ? 0 : next_row + 1;
        end else begin
            next_col = next_col + 1;
        end
    endtask

    // Sends one pixel request and waits until it is taken.
    task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        i_valid <= 1'b1;
        i_red <= r;
        i_green <= g;
        i_blue <= b;
        do @(posedge i_clk); while (!o_ready);
        predict_edge(r, g, b);
        pixels_sent++;
    endtask

    // Sender gap.
    task automatic pause_pixels(input int n);
        i_valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Stops sending until every expected result has come, then lets the pipeline settle.
    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_edges.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Issues one register write request; the caller lowers the valid after the last one.
    task automatic write_reg(input logic [1:0] idx, input logic [12:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            gst_pkg::CFG_IMAGE_WIDTH:    cfg_width = data[10:0];
            gst_pkg::CFG_IMAGE_HEIGHT:   cfg_height = data;
            gst_pkg::CFG_EDGE_THRESHOLD: cfg_threshold = data[7:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [12:0] w, input logic [12:0] h,
                                  input logic [12:0] t);
        write_reg(gst_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(gst_pkg::CFG_IMAGE_HEIGHT, h);
        write_reg(gst_pkg::CFG_EDGE_THRESHOLD, t);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends a run of generated pixels in the given style, with optional sender gaps.
    task automatic send_frame_pixels(input int count, input t_content mode, input bit gaps);
        int         k;
        bit         pick;
        logic [7:0] base_r;
        logic [7:0] base_g;
        logic [7:0] base_b;
        logic [7:0] alt_r;
        logic [7:0] alt_g;
        logic [7:0] alt_b;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        base_r = 8'($urandom);
        base_g = 8'($urandom);
        base_b = 8'($urandom);
        alt_r = 8'($urandom);
        alt_g = 8'($urandom);
        alt_b = 8'($urandom);
        pick = 1'b0;
        for (k = 0; k < count; k++) begin
            if (gaps && $urandom_range(0, 5) == 0) pause_pixels($urandom_range(1, 15));
            case (mode)
                CONTENT_NOISE: begin
                    r = 8'($urandom);
                    g = 8'($urandom);
                    b = 8'($urandom);
                end
                CONTENT_SMOOTH: begin
                    // Small changes in the low bits keep the gradients gentle.
                    r = base_r ^ 8'($urandom_range(0, 3));
                    g = base_g ^ 8'($urandom_range(0, 3));
                    b = base_b ^ 8'($urandom_range(0, 3));
                end
                CONTENT_FLAT: begin
                    r = base_r;
                    g = base_g;
                    b = base_b;
                end
                CONTENT_BLOCKS: begin
                    if ($urandom_range(0, 7) == 0) pick = !pick;
                    r = pick ? alt_r : base_r;
                    g = pick ? alt_g : base_g;
                    b = pick ? alt_b : base_b;
                end
                default: begin
                    r = {8{1'($urandom)}};
                    g = {8{1'($urandom)}};
                    b = {8{1'($urandom)}};
                end
            endcase
            send_pixel(r, g, b);
        end
    endtask

    // Starts under the reset geometry, then changes width and height in the middle of a frame.
    task automatic test_midframe_writes();
        int k;
        for (k = 0; k < 8; k++) send_pixel(8'(k * 30), 8'(k * 30), 8'(k * 30));
        wait_idle();
        // Bits above the register width are dropped.
        write_reg(gst_pkg::CFG_IMAGE_WIDTH, 13'h1803);
        i_cfg_valid <= 1'b0;
        // Column eight now ends row zero; rows one and two follow at width three.
        for (k = 0; k < 6; k++) send_pixel(8'(200 - k * 20), 8'(k * 9), 8'(100 + k * 5));
        wait_idle();
        write_reg(gst_pkg::CFG_IMAGE_HEIGHT, 13'd3);
        i_cfg_valid <= 1'b0;
        // Row two is already the last row, so this pixel ends the frame.
        send_pixel(8'd90, 8'd90, 8'd90);
    endtask

    // A bright left column against black gives a clamped-to-zero level next to a flat window.
    task automatic test_level_extremes();
        int row;
        int col;
        wait_idle();
        write_reg(CFG_UNUSED_INDEX, 13'h1FFF);
        apply_settings(13'd4, 13'd3, 13'd0);
        for (row = 0; row < 3; row++) begin
            for (col = 0; col < 4; col++) begin
                if (col != 0) begin
                    send_pixel(8'd0, 8'd0, 8'd0);
                end else begin
                    case (row)
                        0: send_pixel(8'd255, 8'd0, 8'd0);
                        1: send_pixel(8'd255, 8'd255, 8'd255);
                        default: send_pixel(8'd0, 8'd0, 8'd255);
                    endcase
                end
            end
        end
    endtask

    // Width and height above their maximum are held at the maximum.
    task automatic test_dimension_clamps_high();
        wait_idle();
        // A short part of a wide row; the narrow width below then ends that row.
        apply_settings(13'd2047, 13'd3, 13'($urandom_range(0, 255)));
        send_frame_pixels(WIDE_ROW_ITEMS, CONTENT_SMOOTH, 1'b1);
        wait_idle();
        apply_settings(13'd3, 13'h1FFF, 13'($urandom_range(0, 255)));
        send_frame_pixels(60, CONTENT_BLOCKS, 1'b1);
        // Lowering the height below the current row ends the frame at this row.
        wait_idle();
        write_reg(gst_pkg::CFG_IMAGE_HEIGHT, 13'd2);
        i_cfg_valid <= 1'b0;
        send_frame_pixels(frame_remaining(), CONTENT_NOISE, 1'b1);
    endtask

    // Phases of random settings and frames, some frames cut short before a new setting.
    task automatic test_random_frames();
        int          phase;
        int          frames;
        int          f;
        int          count;
        int          start_items;
        bit          cut;
        logic [12:0] width_val;
        logic [12:0] height_val;
        logic [12:0] thresh_val;
        t_content    mode;
        phase = 0;
        cut = 1'b0;
        width_val = 13'd5;
        start_items = pixels_sent;
        while (pixels_sent - start_items < RANDOM_ITEMS) begin
            wait_idle();
            // After a cut frame the width stays, so the stored rows match the new ones.
            if (!cut) begin
                case ($urandom_range(0, 9))
                    0: width_val = 13'($urandom_range(0, 2));
                    1: width_val = 13'($urandom_range(11, 40));
                    default: width_val = 13'($urandom_range(3, 10));
                endcase
                width_val[12:11] = 2'($urandom);
            end
            if ($urandom_range(0, 7) == 0) height_val = 13'($urandom_range(0, 2));
            else height_val = 13'($urandom_range(3, 6));
            case ($urandom_range(0, 5))
                0: thresh_val = 13'd0;
                1: thresh_val = 13'd255;
                default: thresh_val = 13'($urandom_range(0, 255));
            endcase
            thresh_val[12:8] = 5'($urandom);
            if (phase == 0 && !cut) begin
                width_val = 13'd1;
                height_val = 13'd0;
            end
            if (phase == 1) thresh_val[7:0] = 8'd0;
            if (phase == 2) thresh_val[7:0] = 8'd255;
            apply_settings(width_val, height_val, thresh_val);

            frames = $urandom_range(1, 3);
            for (f = 0; f < frames; f++) begin
                count = frame_remaining();
                cut = 1'b0;
                if (f == frames - 1 && count > 1 && $urandom_range(0, 3) == 0) begin
                    count = $urandom_range(1, count - 1);
                    cut = 1'b1;
                end
                mode = t_content'($urandom_range(0, 4));
                send_frame_pixels(count, mode, $urandom_range(0, 3) != 0);
            end
            phase++;
        end
        if (cut) send_frame_pixels(frame_remaining(), CONTENT_NOISE, 1'b1);
    endtask

    // Closing frames with no gaps and no stalls on either side.
    task automatic test_full_rate();
        int f;
        wait_idle();
        full_rate = 1'b1;
        apply_settings(13'($urandom_range(3, 12)), 13'($urandom_range(3, 5)),
                       13'($urandom_range(0, 255)));
        for (f = 0; f < 3; f++) begin
            send_frame_pixels(frame_remaining(), t_content'($urandom_range(0, 4)), 1'b0);
        end
    endtask

    // Result side: random stall bursts.
    always @(posedge i_clk) begin
        if (full_rate) begin
            stall_left = 0;
            i_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 14);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compares each accepted result with the oldest expected one.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_edges.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: level %0d bit %0b last %0b",
                             o_edge_level, o_edge_bit, o_frame_last);
                end
            end else begin
                want_edge = expected_edges.pop_front();
                if (o_edge_level !== want_edge.level || o_edge_bit !== want_edge.white ||
                    o_frame_last !== want_edge.frame_end) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: expected level %0d bit %0b last %0b, got %0d %0b %0b",
                                 want_edge.level, want_edge.white, want_edge.frame_end,
                                 o_edge_level, o_edge_bit, o_frame_last);
                    end
                end
            end
        end
    end

    // Ends the run when no request of any channel has been taken for too long.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("timeout after %0d quiet cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        int k;
        // Predictor starts from the block's reset state.
        cfg_width = gst_pkg::IMAGE_WIDTH_RESET;
        cfg_height = gst_pkg::IMAGE_HEIGHT_RESET;
        cfg_threshold = gst_pkg::EDGE_THRESHOLD_RESET;
        for (k = 0; k < MAX_WIDTH; k++) begin
            prev_row_gray[k] = 8'd0;
            older_row_gray[k] = 8'd0;
        end
        for (k = 0; k < 9; k++) gray_win[k / 3][k % 3] = 8'd0;
        next_col = 0;
        next_row = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_midframe_writes();
        test_level_extremes();
        test_dimension_clamps_high();
        test_random_frames();
        test_full_rate();

        wait_idle();
        if (fail_count == 0 && expected_edges.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
